@@ hw/rtl/mca_pkg.sv @@
// mca_pkg: shared types and constants for the midi channel allocator
// used by mca_cell, mca_ctrl and midi_channel_allocator; no dependencies
`default_nettype none

package mca_pkg;

  localparam int unsigned DefChannels = 16;
  localparam int unsigned NumTones    = 128;
  localparam int unsigned ToneW       = $clog2(NumTones);
  localparam int unsigned InstrW      = 8;
  localparam int unsigned PairW       = 5;
  localparam int unsigned ChanW       = 4;

  localparam logic KindNoteOn  = 1'b0;
  localparam logic KindNoteOff = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [InstrW-1:0] instrument;
    logic [ToneW-1:0]  tone;
    logic [PairW-1:0]  paired_channel;
  } in_t;

  typedef struct packed {
    logic             accepted;
    logic             program_change;
    logic [ChanW-1:0] channel;
  } out_t;

  // contents of one channel cell
  typedef struct packed {
    logic                valid;
    logic [InstrW-1:0]   instrument;
    logic [NumTones-1:0] tones;
  } cell_t;

  // command broadcast from the controller to every cell
  typedef struct packed {
    logic              shift;
    logic              set_bind;
    logic              tone_on;
    logic              tone_off;
    logic [InstrW-1:0] instrument;
    logic [ToneW-1:0]  tone;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_e;

endpackage

`default_nettype wire

@@ hw/rtl/mca_cell.sv @@
// mca_cell: one channel of the allocator ring, holds binding and sounding tones
// depends on mca_pkg
`default_nettype none

module mca_cell import mca_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cmd_t  cmd_i,
  input  wire logic  sel_i,
  input  wire cell_t nb_i,
  output cell_t      q_o
);

  cell_t cell_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (cmd_i.shift) begin
      // rotate toward the head of the ring
      cell_q <= nb_i;
    end else if (sel_i) begin
      if (cmd_i.set_bind) begin
        cell_q.valid      <= 1'b1;
        cell_q.instrument <= cmd_i.instrument;
      end
      if (cmd_i.tone_on) begin
        cell_q.tones[cmd_i.tone] <= 1'b1;
      end
      if (cmd_i.tone_off) begin
        cell_q.tones[cmd_i.tone] <= 1'b0;
      end
    end
  end

  assign q_o = cell_q;

endmodule

`default_nettype wire

@@ hw/rtl/mca_ctrl.sv @@
// mca_ctrl: sequencer that rotates the cell ring past the head, picks a channel
// and issues the update; holds the output register. depends on mca_pkg
`default_nettype none

module mca_ctrl import mca_pkg::*; #(
  parameter int unsigned Channels = DefChannels
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_t                 in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_t                     out_data_o,
  input  wire cell_t               head_i,
  output cmd_t                     cmd_o,
  output logic [Channels-1:0]      sel_o
);

  localparam int unsigned CntW = $clog2(Channels);

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  in_t  item_q;
  logic hit_q, free_q, sil_q, pair_q;
  logic [CntW-1:0] hit_idx_q, free_idx_q, sil_idx_q;
  logic out_valid_q;
  out_t out_q;

  logic in_fire, scan_last, apply_fire;
  logic head_silent, head_hit, head_free, pair_range, pair_here;

  logic            dec_acc, dec_pc, dec_bind, dec_on, dec_off;
  logic [CntW-1:0] dec_idx;
  logic [4:0]      dec_ch5;

  assign in_fire    = in_valid_i && !in_stall_o;
  assign scan_last  = (cnt_q == CntW'(Channels - 1));
  assign apply_fire = (state_q == ST_APPLY) && (!out_valid_q || !out_stall_i);

  assign head_silent = (head_i.tones == '0);
  assign head_hit    = head_i.valid && (head_i.instrument == item_q.instrument);
  assign head_free   = !head_i.valid && head_silent;
  assign pair_range  = ({1'b0, item_q.paired_channel} < 6'(Channels));
  assign pair_here   = pair_range && (item_q.paired_channel[CntW-1:0] == cnt_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_SCAN;
      ST_SCAN:  if (scan_last) state_d = ST_APPLY;
      ST_APPLY: if (apply_fire) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // decision from the scan flags
  always_comb begin
    dec_acc  = 1'b0;
    dec_pc   = 1'b0;
    dec_bind = 1'b0;
    dec_on   = 1'b0;
    dec_off  = 1'b0;
    dec_idx  = '0;
    if (item_q.kind == KindNoteOn) begin
      if (hit_q) begin
        dec_acc = 1'b1;
        dec_on  = 1'b1;
        dec_idx = hit_idx_q;
      end else if (free_q || sil_q) begin
        dec_acc  = 1'b1;
        dec_pc   = 1'b1;
        dec_bind = 1'b1;
        dec_on   = 1'b1;
        dec_idx  = free_q ? free_idx_q : sil_idx_q;
      end
    end else if (pair_q) begin
      dec_acc = 1'b1;
      dec_off = 1'b1;
      dec_idx = item_q.paired_channel[CntW-1:0];
    end
  end

  assign dec_ch5 = 5'(dec_idx);

  // outputs
  always_comb begin
    in_stall_o          = (state_q != ST_IDLE);
    cmd_o.shift         = (state_q == ST_SCAN);
    cmd_o.set_bind      = apply_fire && dec_bind;
    cmd_o.tone_on       = apply_fire && dec_on;
    cmd_o.tone_off      = apply_fire && dec_off;
    cmd_o.instrument    = item_q.instrument;
    cmd_o.tone          = item_q.tone;
    sel_o               = '0;
    if (apply_fire && dec_acc) begin
      sel_o[dec_idx] = 1'b1;
    end
    cnt_d = (state_q == ST_SCAN && !scan_last) ? cnt_q + 1'b1 : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      sil_q       <= 1'b0;
      pair_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (in_fire) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
        sil_q  <= 1'b0;
        pair_q <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        // first qualifying channel wins for each class
        if (head_hit && !hit_q) hit_q <= 1'b1;
        if (head_free && !free_q) free_q <= 1'b1;
        if (head_silent && !sil_q) sil_q <= 1'b1;
        if (pair_here) pair_q <= head_hit;
      end
      if (apply_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_data_i;
    end
    if (state_q == ST_SCAN) begin
      if (head_hit && !hit_q) hit_idx_q <= cnt_q;
      if (head_free && !free_q) free_idx_q <= cnt_q;
      if (head_silent && !sil_q) sil_idx_q <= cnt_q;
    end
    if (apply_fire) begin
      out_q.accepted       <= dec_acc;
      out_q.program_change <= dec_pc;
      out_q.channel        <= dec_acc ? dec_ch5[ChanW-1:0] : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_sel_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(sel_o))
    else $error("more than one cell selected");

  a_no_write_while_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.shift |-> (sel_o == '0))
    else $error("cell write during rotation");

  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_SCAN) |-> (cnt_q == '0))
    else $error("scan counter not parked");

  a_apply_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    apply_fire |=> out_valid_q)
    else $error("result lost after apply");

  a_pc_implies_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.program_change) |-> out_q.accepted)
    else $error("program change on rejected note");

endmodule

`default_nettype wire

@@ hw/rtl/midi_channel_allocator.sv @@
// midi_channel_allocator: top level, a ring of channel cells and its sequencer
// depends on mca_pkg, mca_cell, mca_ctrl
//
//   port group    direction  handshake              payload
//   input item    in         in_valid_i/in_stall_o  in_data_i  (in_t)
//   result item   out        out_valid_o/out_stall_i out_data_o (out_t)
//
// each item is taken in the idle state, then the ring is rotated once past the
// head cell, then the chosen cell is updated once the output register can take the result
// one item is in work at a time; the result waits in an output register, so
// the next item is taken while a stalled result is still held
// reset clears every channel binding and tone set at once
`default_nettype none

module midi_channel_allocator import mca_pkg::*; #(
  parameter int unsigned Channels = DefChannels
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  cell_t               cell_w [Channels];
  cmd_t                cmd_w;
  logic [Channels-1:0] sel_w;

  mca_ctrl #(
    .Channels (Channels)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .head_i      (cell_w[0]),
    .cmd_o       (cmd_w),
    .sel_o       (sel_w)
  );

  for (genvar k = 0; k < Channels; k++) begin : g_cell
    mca_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd_w),
      .sel_i  (sel_w[k]),
      .nb_i   (cell_w[(k + 1) % Channels]),
      .q_o    (cell_w[k])
    );
  end

endmodule

`default_nettype wire
